/* rtl/dahdsr_pkg.sv */
// Shared types, codes and constants of the DAHDSR envelope generator.
`timescale 1ns / 1ps

package dahdsr_pkg;

   // Field widths
   localparam int SAMPLE_W   = 24;
   localparam int LEVEL_W    = 17;
   localparam int FACTOR_W   = 16;
   localparam int VELOCITY_W = 7;
   localparam int FUNC_W     = 2;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Level accumulator: 1.0 is 2^30, never above 1.0
   localparam int ACC_W       = 31;
   localparam int LEVEL_SHIFT = ACC_W - LEVEL_W;
   localparam logic [ACC_W-1:0]   ONE_Q30   = ACC_W'(1) << 30;
   localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(65536);

   // Remaining samples of a segment, two's complement
   localparam int COUNT_W = 27;

   // Velocity scaling of the attack in modulation mode
   localparam int ATTACK_VEL_BASE = 145;
   localparam int ATTACK_VEL_DIV  = 144;

   // Function codes of an input word
   localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_NOTE_ON  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_NOTE_OFF = 2'd2;

   // Shared arithmetic unit
   localparam int ALU_A_W   = 32;
   localparam int ALU_B_W   = 25;
   localparam int MUL_STEPS = 17;
   localparam int DIV_STEPS = 32;
   localparam int ALU_P_W   = ALU_A_W + MUL_STEPS;

   typedef enum logic [2:0] {
      SEG_NONE    = 3'd0,
      SEG_DELAY   = 3'd1,
      SEG_ATTACK  = 3'd2,
      SEG_HOLD    = 3'd3,
      SEG_DECAY   = 3'd4,
      SEG_SUSTAIN = 3'd5,
      SEG_RELEASE = 3'd6,
      SEG_DONE    = 3'd7
   } seg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_TICK_MUL,
      ST_TICK_END,
      ST_ENTER,
      ST_ATK_MUL,
      ST_ATK_DIV,
      ST_DEC_MUL,
      ST_SLOPE_DIV,
      ST_OUT
   } state_type;

   typedef enum logic {
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic               start;
      alu_op_type         op;
      logic [ALU_A_W-1:0] a;
      logic [ALU_B_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic               done;
      logic [ALU_P_W-1:0] result;
   } alu_rsp_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] delay_samples;
      logic [SAMPLE_W-1:0] attack_samples;
      logic [SAMPLE_W-1:0] hold_samples;
      logic [SAMPLE_W-1:0] decay_samples;
      logic [LEVEL_W-1:0]  sustain_level;
      logic [SAMPLE_W-1:0] release_samples;
      logic [FACTOR_W-1:0] decay_factor;
      logic [FACTOR_W-1:0] release_factor;
   } cfg_type;

   typedef struct packed {
      logic [FUNC_W-1:0]     func;
      logic [VELOCITY_W-1:0] velocity;
   } req_word_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      seg_type            segment;
      logic               finished;
   } rsp_word_type;

endpackage

/* rtl/dahdsr_envelope_generator.sv */
// DAHDSR envelope generator top level: sequencer, envelope state and result register.
// One word at a time. A tick outside none, sustain and done multiplies on the shared unit;
// attack entry divides in amplitude mode; modulation mode scales it by velocity with a
// multiply and two divides. Modulation decay entry multiplies and divides; release divides.
// The unit runs 17 multiply and 32 divide steps; words wait for the registered result.
// Synchronous active-high reset: segment none, level zero, registers to their defaults.
`timescale 1ns / 1ps

module dahdsr_envelope_generator
   import dahdsr_pkg::*;
#(
   parameter int BLOCK_SAMPLES        = 64,
   parameter int AMP_MODE             = 1,
   parameter int FAST_RELEASE_SAMPLES = 480
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_word_type          rsp_word,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam bit AMP = (AMP_MODE != 0);

   cfg_type     cfg;
   alu_req_type alu_req;
   alu_rsp_type alu_rsp;

   state_type             state_ff, state_in;
   seg_type               seg_ff, seg_in;
   seg_type               from_ff, from_in;
   logic [ACC_W-1:0]      level_ff, level_in;
   logic [ACC_W-1:0]      mag_ff, mag_in;
   logic                  neg_ff, neg_in;
   logic                  expo_ff, expo_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [VELOCITY_W-1:0] vel_ff, vel_in;
   logic [FUNC_W-1:0]     func_ff, func_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   dahdsr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dahdsr_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   // derived config values
   logic [LEVEL_W-1:0]  sus_clamp;
   logic [ACC_W-1:0]    sus_q30;
   logic [SAMPLE_W-1:0] rel_n;

   assign sus_clamp = (cfg.sustain_level > LEVEL_ONE) ? LEVEL_ONE : cfg.sustain_level;
   assign sus_q30   = {sus_clamp, {LEVEL_SHIFT{1'b0}}};
   assign rel_n     = (cfg.release_samples != '0) ? cfg.release_samples
                                                  : SAMPLE_W'(FAST_RELEASE_SAMPLES);

   // next segment of nonzero length after from_ff
   seg_type target;

   always_comb begin
      priority if (from_ff == SEG_NONE && cfg.delay_samples != '0) begin
         target = SEG_DELAY;
      end else if (from_ff <= SEG_DELAY && cfg.attack_samples != '0) begin
         target = SEG_ATTACK;
      end else if (from_ff <= SEG_ATTACK && cfg.hold_samples != '0) begin
         target = SEG_HOLD;
      end else if (from_ff <= SEG_HOLD && cfg.decay_samples != '0) begin
         target = SEG_DECAY;
      end else if (from_ff <= SEG_DECAY) begin
         target = SEG_SUSTAIN;
      end else if (from_ff == SEG_SUSTAIN) begin
         target = SEG_RELEASE;
      end else begin
         target = SEG_DONE;
      end
   end

   // tick arithmetic on the unit's product
   logic               tick_idle;
   logic               decay_hold;
   logic               out_free;
   logic [ALU_P_W-1:0] lvl_up;
   logic [ACC_W-1:0]   lin_up;
   logic [ACC_W-1:0]   lin_down;
   logic [ACC_W-1:0]   expo_level;
   logic [COUNT_W-1:0] count_dec;
   logic               count_end;
   logic [ALU_B_W-1:0] quo_n;
   logic [ALU_B_W-1:0] atk_n;

   always_comb begin
      tick_idle  = (seg_ff == SEG_NONE) || (seg_ff == SEG_SUSTAIN) || (seg_ff == SEG_DONE);
      decay_hold = (seg_ff == SEG_DECAY) && expo_ff && (cfg.sustain_level != '0);
      out_free   = !rsp_valid_ff || !rsp_stall;

      lvl_up     = ALU_P_W'(level_ff) + alu_rsp.result;
      lin_up     = (lvl_up > ALU_P_W'(ONE_Q30)) ? ONE_Q30 : lvl_up[ACC_W-1:0];
      lin_down   = (alu_rsp.result > ALU_P_W'(level_ff)) ? '0
                 : level_ff - alu_rsp.result[ACC_W-1:0];
      expo_level = alu_rsp.result[ACC_W+FACTOR_W-1:FACTOR_W];

      count_dec  = count_ff - COUNT_W'(BLOCK_SAMPLES);
      count_end  = count_dec[COUNT_W-1] || (count_dec == '0);

      // scaled attack length, never zero
      quo_n      = alu_rsp.result[ALU_B_W-1:0];
      atk_n      = (quo_n == '0) ? ALU_B_W'(1) : quo_n;
   end

   // sequencer: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            unique case (func_ff)
               FUNC_TICK:     state_in = tick_idle ? ST_OUT : ST_TICK_MUL;
               FUNC_NOTE_ON:  state_in = ST_ENTER;
               FUNC_NOTE_OFF: state_in = (seg_ff < SEG_RELEASE) ? ST_ENTER : ST_OUT;
               default:       state_in = ST_OUT;
            endcase
         end
         ST_TICK_MUL: begin
            if (alu_rsp.done) state_in = ST_TICK_END;
         end
         ST_TICK_END: begin
            if (decay_hold) begin
               state_in = (level_ff <= sus_q30) ? ST_ENTER : ST_OUT;
            end else begin
               state_in = count_end ? ST_ENTER : ST_OUT;
            end
         end
         ST_ENTER: begin
            unique case (target)
               SEG_ATTACK:  state_in = AMP ? ST_SLOPE_DIV : ST_ATK_MUL;
               SEG_DECAY:   state_in = AMP ? ST_OUT : ST_DEC_MUL;
               SEG_RELEASE: state_in = AMP ? ST_OUT : ST_SLOPE_DIV;
               default:     state_in = ST_OUT;
            endcase
         end
         ST_ATK_MUL: begin
            if (alu_rsp.done) state_in = ST_ATK_DIV;
         end
         ST_ATK_DIV: begin
            if (alu_rsp.done) state_in = ST_SLOPE_DIV;
         end
         ST_DEC_MUL: begin
            if (alu_rsp.done) state_in = ST_SLOPE_DIV;
         end
         ST_SLOPE_DIV: begin
            if (alu_rsp.done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer: datapath updates and unit requests
   always_comb begin
      seg_in       = seg_ff;
      from_in      = from_ff;
      level_in     = level_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      expo_in      = expo_ff;
      count_in     = count_ff;
      vel_in       = vel_ff;
      func_in      = func_ff;
      rsp_word_in  = rsp_word_ff;
      alu_req      = '{start: 1'b0, op: ALU_MUL, a: '0, b: '0};
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in = req_word.func;
               if (req_word.func == FUNC_NOTE_ON) vel_in = req_word.velocity;
            end
         end
         ST_DECODE: begin
            unique case (func_ff)
               FUNC_TICK: begin
                  // level*factor, or slope magnitude*block
                  if (!tick_idle) begin
                     alu_req.start = 1'b1;
                     alu_req.op    = ALU_MUL;
                     alu_req.a     = expo_ff ? ALU_A_W'(level_ff) : ALU_A_W'(mag_ff);
                     alu_req.b     = expo_ff ? ALU_B_W'(mag_ff[FACTOR_W-1:0])
                                             : ALU_B_W'(BLOCK_SAMPLES);
                  end
               end
               FUNC_NOTE_ON:  from_in = SEG_NONE;
               FUNC_NOTE_OFF: from_in = SEG_SUSTAIN;
               default: ;
            endcase
         end
         ST_TICK_MUL: begin
            if (alu_rsp.done) begin
               level_in = expo_ff ? expo_level : (neg_ff ? lin_down : lin_up);
            end
         end
         ST_TICK_END: begin
            if (decay_hold) begin
               from_in = SEG_DECAY;
            end else begin
               count_in = count_dec;
               from_in  = seg_ff;
            end
         end
         ST_ENTER: begin
            seg_in = target;
            unique case (target)
               SEG_DELAY: begin
                  level_in = '0;
                  mag_in   = '0;
                  neg_in   = 1'b0;
                  expo_in  = 1'b0;
                  count_in = COUNT_W'(cfg.delay_samples);
               end
               SEG_ATTACK: begin
                  level_in      = '0;
                  neg_in        = 1'b0;
                  expo_in       = 1'b0;
                  alu_req.start = 1'b1;
                  if (AMP) begin
                     count_in  = COUNT_W'(cfg.attack_samples);
                     alu_req.op = ALU_DIV;
                     alu_req.a  = ALU_A_W'(ONE_Q30);
                     alu_req.b  = ALU_B_W'(cfg.attack_samples);
                  end else begin
                     alu_req.op = ALU_MUL;
                     alu_req.a  = ALU_A_W'(cfg.attack_samples);
                     alu_req.b  = ALU_B_W'(ATTACK_VEL_BASE) - ALU_B_W'(vel_ff);
                  end
               end
               SEG_HOLD: begin
                  level_in = ONE_Q30;
                  mag_in   = '0;
                  neg_in   = 1'b0;
                  expo_in  = 1'b0;
                  count_in = COUNT_W'(cfg.hold_samples);
               end
               SEG_DECAY: begin
                  level_in = ONE_Q30;
                  if (AMP) begin
                     mag_in   = ACC_W'(cfg.decay_factor);
                     neg_in   = 1'b0;
                     expo_in  = 1'b1;
                     count_in = COUNT_W'(cfg.decay_samples);
                  end else begin
                     neg_in        = 1'b1;
                     expo_in       = 1'b0;
                     alu_req.start = 1'b1;
                     alu_req.op    = ALU_MUL;
                     alu_req.a     = ALU_A_W'(cfg.decay_samples);
                     alu_req.b     = ALU_B_W'(LEVEL_ONE) - ALU_B_W'(sus_clamp);
                  end
               end
               SEG_SUSTAIN: begin
                  level_in = sus_q30;
                  mag_in   = '0;
                  neg_in   = 1'b0;
                  expo_in  = 1'b0;
                  count_in = '0;
               end
               SEG_RELEASE: begin
                  // release starts from the current level
                  count_in = COUNT_W'(rel_n);
                  if (AMP) begin
                     mag_in  = ACC_W'(cfg.release_factor);
                     neg_in  = 1'b0;
                     expo_in = 1'b1;
                  end else begin
                     neg_in        = 1'b1;
                     expo_in       = 1'b0;
                     alu_req.start = 1'b1;
                     alu_req.op    = ALU_DIV;
                     alu_req.a     = ALU_A_W'(level_ff);
                     alu_req.b     = ALU_B_W'(rel_n);
                  end
               end
               SEG_NONE, SEG_DONE: begin
                  level_in = '0;
                  mag_in   = '0;
                  neg_in   = 1'b0;
                  expo_in  = 1'b0;
                  count_in = '0;
               end
            endcase
         end
         ST_ATK_MUL: begin
            // scaled length = attack*(145-velocity)/144
            if (alu_rsp.done) begin
               alu_req.start = 1'b1;
               alu_req.op    = ALU_DIV;
               alu_req.a     = alu_rsp.result[ALU_A_W-1:0];
               alu_req.b     = ALU_B_W'(ATTACK_VEL_DIV);
            end
         end
         ST_ATK_DIV: begin
            if (alu_rsp.done) begin
               count_in      = COUNT_W'(atk_n);
               alu_req.start = 1'b1;
               alu_req.op    = ALU_DIV;
               alu_req.a     = ALU_A_W'(ONE_Q30);
               alu_req.b     = atk_n;
            end
         end
         ST_DEC_MUL: begin
            // decay length scaled by distance to sustain
            if (alu_rsp.done) begin
               count_in      = COUNT_W'(alu_rsp.result[FACTOR_W+ALU_B_W-1:FACTOR_W]);
               alu_req.start = 1'b1;
               alu_req.op    = ALU_DIV;
               alu_req.a     = ALU_A_W'(ONE_Q30);
               alu_req.b     = ALU_B_W'(cfg.decay_samples);
            end
         end
         ST_SLOPE_DIV: begin
            if (alu_rsp.done) mag_in = alu_rsp.result[ACC_W-1:0];
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{
                  level:    level_ff[ACC_W-1:LEVEL_SHIFT],
                  segment:  seg_ff,
                  finished: (seg_ff == SEG_DONE)
               };
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seg_ff       <= SEG_NONE;
         from_ff      <= SEG_NONE;
         level_ff     <= '0;
         mag_ff       <= '0;
         neg_ff       <= 1'b0;
         expo_ff      <= 1'b0;
         count_ff     <= '0;
         vel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seg_ff       <= seg_in;
         from_ff      <= from_in;
         level_ff     <= level_in;
         mag_ff       <= mag_in;
         neg_ff       <= neg_in;
         expo_ff      <= expo_in;
         count_ff     <= count_in;
         vel_ff       <= vel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff     <= func_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

/* rtl/dahdsr_alu.sv */
// Shared iterative unit: shift-add multiply and restoring divide, one bit a cycle.
`timescale 1ns / 1ps

module dahdsr_alu
   import dahdsr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  alu_req_type alu_req,
   output alu_rsp_type alu_rsp
);

   localparam int STEP_W = $clog2(DIV_STEPS);
   localparam int REM_W  = ALU_B_W + 1;
   localparam int WORK_W = REM_W + ALU_A_W;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   alu_op_type         op_ff, op_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   logic [ALU_A_W-1:0] a_ff, a_in;
   logic [ALU_B_W-1:0] b_ff, b_in;
   logic [WORK_W-1:0]  work_ff, work_in;

   // multiply step: add multiplicand on low bit, shift right
   logic [ALU_A_W:0]   mul_sum;
   logic [WORK_W-1:0]  mul_next;
   // divide step: shift in next dividend bit, subtract if it fits
   logic [REM_W-1:0]   div_rem;
   logic [ALU_A_W-1:0] div_quo;
   logic [REM_W-1:0]   div_try;
   logic [REM_W-1:0]   div_sub;
   logic               div_fit;
   logic [WORK_W-1:0]  div_next;

   always_comb begin
      mul_sum  = {1'b0, work_ff[ALU_P_W-1:MUL_STEPS]}
               + (work_ff[0] ? {1'b0, a_ff} : {(ALU_A_W+1){1'b0}});
      mul_next = WORK_W'({mul_sum, work_ff[MUL_STEPS-1:1]});

      div_rem  = work_ff[WORK_W-1:ALU_A_W];
      div_quo  = work_ff[ALU_A_W-1:0];
      div_try  = {div_rem[ALU_B_W-1:0], div_quo[ALU_A_W-1]};
      div_fit  = (div_try >= {1'b0, b_ff});
      div_sub  = div_try - {1'b0, b_ff};
      div_next = {(div_fit ? div_sub : div_try), div_quo[ALU_A_W-2:0], div_fit};
   end

   // sequencing of the steps
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      work_in = work_ff;
      if (alu_req.start) begin
         busy_in = 1'b1;
         op_in   = alu_req.op;
         a_in    = alu_req.a;
         b_in    = alu_req.b;
         unique case (alu_req.op)
            ALU_MUL: begin
               work_in = WORK_W'(alu_req.b[MUL_STEPS-1:0]);
               cnt_in  = STEP_W'(MUL_STEPS - 1);
            end
            ALU_DIV: begin
               work_in = WORK_W'(alu_req.a);
               cnt_in  = STEP_W'(DIV_STEPS - 1);
            end
         endcase
      end else if (busy_ff) begin
         work_in = (op_ff == ALU_MUL) ? mul_next : div_next;
         cnt_in  = cnt_ff - STEP_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff   <= op_in;
      cnt_ff  <= cnt_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      work_ff <= work_in;
   end

   // product, or zero-extended quotient
   assign alu_rsp.done   = done_ff;
   assign alu_rsp.result = (op_ff == ALU_MUL) ? work_ff[ALU_P_W-1:0]
                                              : ALU_P_W'(work_ff[ALU_A_W-1:0]);

endmodule

/* rtl/dahdsr_csr.sv */
// APB-style register file holding the envelope configuration.
`timescale 1ns / 1ps

module dahdsr_csr
   import dahdsr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   localparam logic [2:0] REG_DELAY          = 3'd0;
   localparam logic [2:0] REG_ATTACK         = 3'd1;
   localparam logic [2:0] REG_HOLD           = 3'd2;
   localparam logic [2:0] REG_DECAY          = 3'd3;
   localparam logic [2:0] REG_SUSTAIN        = 3'd4;
   localparam logic [2:0] REG_RELEASE        = 3'd5;
   localparam logic [2:0] REG_DECAY_FACTOR   = 3'd6;
   localparam logic [2:0] REG_RELEASE_FACTOR = 3'd7;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   // write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_DELAY:          cfg_in.delay_samples   = pwdata[SAMPLE_W-1:0];
            REG_ATTACK:         cfg_in.attack_samples  = pwdata[SAMPLE_W-1:0];
            REG_HOLD:           cfg_in.hold_samples    = pwdata[SAMPLE_W-1:0];
            REG_DECAY:          cfg_in.decay_samples   = pwdata[SAMPLE_W-1:0];
            REG_SUSTAIN:        cfg_in.sustain_level   = pwdata[LEVEL_W-1:0];
            REG_RELEASE:        cfg_in.release_samples = pwdata[SAMPLE_W-1:0];
            REG_DECAY_FACTOR:   cfg_in.decay_factor    = pwdata[FACTOR_W-1:0];
            REG_RELEASE_FACTOR: cfg_in.release_factor  = pwdata[FACTOR_W-1:0];
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         REG_DELAY:          prdata = CSR_DATA_W'(cfg_ff.delay_samples);
         REG_ATTACK:         prdata = CSR_DATA_W'(cfg_ff.attack_samples);
         REG_HOLD:           prdata = CSR_DATA_W'(cfg_ff.hold_samples);
         REG_DECAY:          prdata = CSR_DATA_W'(cfg_ff.decay_samples);
         REG_SUSTAIN:        prdata = CSR_DATA_W'(cfg_ff.sustain_level);
         REG_RELEASE:        prdata = CSR_DATA_W'(cfg_ff.release_samples);
         REG_DECAY_FACTOR:   prdata = CSR_DATA_W'(cfg_ff.decay_factor);
         REG_RELEASE_FACTOR: prdata = CSR_DATA_W'(cfg_ff.release_factor);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{
            delay_samples:   '0,
            attack_samples:  '0,
            hold_samples:    '0,
            decay_samples:   '0,
            sustain_level:   LEVEL_ONE,
            release_samples: '0,
            decay_factor:    '0,
            release_factor:  '0
         };
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/dahdsr_checker.sv */
// Port-level assertions for the DAHDSR envelope generator, bound to the top level.
`timescale 1ns / 1ps

module dahdsr_checker
   import dahdsr_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_word_type          rsp_word
);

   // an accepted word keeps the block busy for at least the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input accepted again right after an accept");

   // finished flag tracks the done segment
   a_finished_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.finished == (rsp_word.segment == SEG_DONE)))
      else $error("finished flag disagrees with segment");

   // level never above full scale
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.level <= LEVEL_ONE))
      else $error("level above full scale");

   // idle and done segments report zero level
   a_level_rest: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_word.segment == SEG_NONE || rsp_word.segment == SEG_DONE))
      |-> (rsp_word.level == '0))
      else $error("nonzero level in none or done");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
      else $error("stalled result word changed");

endmodule

bind dahdsr_envelope_generator dahdsr_checker u_checker (.*);

/* tb/tb.sv */
// Self-checking testbench for the DAHDSR envelope generator: driver, monitor, predictor.
`timescale 1ns / 1ps

module tb;
   import dahdsr_pkg::*;

   localparam int BLOCK_SAMPLES        = 64;
   localparam int AMP_MODE             = 1;
   localparam int FAST_RELEASE_SAMPLES = 480;
   localparam longint FULL_SCALE       = longint'(1) << 30;
   localparam int RUN_LIMIT_NS         = 8_000_000;

   // CSR register indexes
   localparam int REG_DELAY          = 0;
   localparam int REG_ATTACK         = 1;
   localparam int REG_HOLD           = 2;
   localparam int REG_DECAY          = 3;
   localparam int REG_SUSTAIN        = 4;
   localparam int REG_RELEASE        = 5;
   localparam int REG_DECAY_FACTOR   = 6;
   localparam int REG_RELEASE_FACTOR = 7;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_word_type          req_word  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_word_type          rsp_word;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   dahdsr_envelope_generator #(
      .BLOCK_SAMPLES       (BLOCK_SAMPLES),
      .AMP_MODE            (AMP_MODE),
      .FAST_RELEASE_SAMPLES(FAST_RELEASE_SAMPLES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #6 clock = ~clock;

   // Envelope predictor state and its copy of the registers
   cfg_type      env_cfg;
   seg_type      env_seg   = SEG_NONE;
   logic [31:0]  env_level = '0;
   int           env_slope = 0;
   int           env_left  = 0;
   bit           env_expo  = 1'b0;
   logic [6:0]   env_vel   = '0;

   req_word_type word_backlog[$];
   rsp_word_type expected_env[$];
   rsp_word_type env_want;
   int           words_queued = 0;
   int           words_taken  = 0;
   int           mismatches   = 0;
   logic         req_taken    = 1'b0;
   bit           idle_on      = 1'b1;
   int           send_gap     = 0;
   int           stall_left   = 0;

   function automatic logic [31:0] sustain_q30();
      logic [31:0] s;
      s = (env_cfg.sustain_level > 17'd65536) ? 32'd65536 : 32'(env_cfg.sustain_level);
      return s << 14;
   endfunction

   function automatic void env_set(seg_type s, logic [31:0] lvl, int slope, int count, bit expo);
      env_seg   = s;
      env_level = lvl;
      env_slope = slope;
      env_left  = count;
      env_expo  = expo;
   endfunction

   // Leave a segment and enter the next one of nonzero length
   function automatic void env_enter_next(seg_type from);
      longint n;
      longint len;
      if (from == SEG_NONE && env_cfg.delay_samples != 0) begin
         env_set(SEG_DELAY, 32'd0, 0, int'(env_cfg.delay_samples), 1'b0);
         return;
      end
      if (from <= SEG_DELAY && env_cfg.attack_samples != 0) begin
         n = longint'(env_cfg.attack_samples);
         if (AMP_MODE == 0)
            n = n * longint'(ATTACK_VEL_BASE - int'(env_vel)) / ATTACK_VEL_DIV;
         if (n == 0) n = 1;
         env_set(SEG_ATTACK, 32'd0, int'(FULL_SCALE / n), int'(n), 1'b0);
         return;
      end
      if (from <= SEG_ATTACK && env_cfg.hold_samples != 0) begin
         env_set(SEG_HOLD, 32'(FULL_SCALE), 0, int'(env_cfg.hold_samples), 1'b0);
         return;
      end
      if (from <= SEG_HOLD && env_cfg.decay_samples != 0) begin
         if (AMP_MODE != 0) begin
            env_set(SEG_DECAY, 32'(FULL_SCALE), int'(env_cfg.decay_factor),
                    int'(env_cfg.decay_samples), 1'b1);
         end else begin
            len = (longint'(env_cfg.decay_samples)
                   * (65536 - longint'({32'd0, sustain_q30() >> 14}))) >>> 16;
            env_set(SEG_DECAY, 32'(FULL_SCALE),
                    -int'(FULL_SCALE / longint'(env_cfg.decay_samples)), int'(len), 1'b0);
         end
         return;
      end
      if (from <= SEG_DECAY) begin
         env_set(SEG_SUSTAIN, sustain_q30(), 0, 0, 1'b0);
         return;
      end
      if (from == SEG_SUSTAIN) begin
         n = (env_cfg.release_samples != 0) ? longint'(env_cfg.release_samples)
                                           : longint'(FAST_RELEASE_SAMPLES);
         if (AMP_MODE != 0)
            env_set(SEG_RELEASE, env_level, int'(env_cfg.release_factor), int'(n), 1'b1);
         else
            env_set(SEG_RELEASE, env_level, -int'(longint'({32'd0, env_level}) / n),
                    int'(n), 1'b0);
         return;
      end
      env_set(SEG_DONE, 32'd0, 0, 0, 1'b0);
   endfunction

   // One block of samples
   function automatic void env_tick();
      seg_type from;
      longint  v;
      from = env_seg;
      if (from == SEG_NONE || from == SEG_SUSTAIN || from == SEG_DONE) return;
      if (env_expo) begin
         env_level = 32'((64'(env_level) * 64'(env_slope[15:0])) >> 16);
      end else begin
         v = longint'({32'd0, env_level}) + longint'(env_slope) * BLOCK_SAMPLES;
         if (v < 0) v = 0;
         if (v > FULL_SCALE) v = FULL_SCALE;
         env_level = 32'(v);
      end
      // amplitude decay ends on the level, unless sustain is zero
      if (from == SEG_DECAY && env_expo && env_cfg.sustain_level != 0) begin
         if (env_level <= sustain_q30()) env_enter_next(SEG_DECAY);
         return;
      end
      env_left -= BLOCK_SAMPLES;
      if (env_left <= 0) env_enter_next(from);
   endfunction

   function automatic rsp_word_type env_apply(req_word_type w);
      rsp_word_type r;
      logic [31:0]  lvl;
      case (w.func)
         FUNC_TICK: env_tick();
         FUNC_NOTE_ON: begin
            env_vel = w.velocity;
            env_set(SEG_NONE, 32'd0, 0, 0, 1'b0);
            env_enter_next(SEG_NONE);
         end
         FUNC_NOTE_OFF: begin
            if (env_seg < SEG_RELEASE) env_enter_next(SEG_SUSTAIN);
         end
         default: ;
      endcase
      lvl = env_level >> 14;
      if (lvl > 32'd65536) lvl = 32'd65536;
      r.level    = lvl[LEVEL_W-1:0];
      r.segment  = env_seg;
      r.finished = (env_seg == SEG_DONE);
      return r;
   endfunction

   // Input driver: feeds words from the backlog, with random gap bursts
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap != 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (idle_on && word_backlog.size() != 0 && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 13);
            req_valid <= 1'b0;
         end else if (word_backlog.size() != 0) begin
            req_word  <= word_backlog.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side stall bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 13);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: check each result word, predict each accepted input word
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_env.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result: level %0d segment %0d finished %0d",
                           rsp_word.level, rsp_word.segment, rsp_word.finished);
               mismatches++;
            end else begin
               env_want = expected_env.pop_front();
               if (rsp_word.level !== env_want.level || rsp_word.segment !== env_want.segment
                   || rsp_word.finished !== env_want.finished) begin
                  if (mismatches < 10)
                     $display("mismatch: level %0d/%0d segment %0d/%0d finished %0d/%0d (exp/act)",
                              env_want.level, rsp_word.level, env_want.segment,
                              rsp_word.segment, env_want.finished, rsp_word.finished);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_env.insert(expected_env.size(), env_apply(req_word));
            words_taken++;
         end
      end
      req_taken <= !reset && req_valid && !req_stall;
   end

   task automatic csr_write(input int index, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(index * 4);
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (index)
         REG_DELAY:          env_cfg.delay_samples   = value[SAMPLE_W-1:0];
         REG_ATTACK:         env_cfg.attack_samples  = value[SAMPLE_W-1:0];
         REG_HOLD:           env_cfg.hold_samples    = value[SAMPLE_W-1:0];
         REG_DECAY:          env_cfg.decay_samples   = value[SAMPLE_W-1:0];
         REG_SUSTAIN:        env_cfg.sustain_level   = value[LEVEL_W-1:0];
         REG_RELEASE:        env_cfg.release_samples = value[SAMPLE_W-1:0];
         REG_DECAY_FACTOR:   env_cfg.decay_factor    = value[FACTOR_W-1:0];
         REG_RELEASE_FACTOR: env_cfg.release_factor  = value[FACTOR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_setup(input logic [31:0] dly, atk, hld, dcy, sus, rel, dfac, rfac);
      csr_write(REG_DELAY, dly);
      csr_write(REG_ATTACK, atk);
      csr_write(REG_HOLD, hld);
      csr_write(REG_DECAY, dcy);
      csr_write(REG_SUSTAIN, sus);
      csr_write(REG_RELEASE, rel);
      csr_write(REG_DECAY_FACTOR, dfac);
      csr_write(REG_RELEASE_FACTOR, rfac);
   endtask

   // Mostly short segments so that sequences reach release and done
   function automatic logic [31:0] pick_len();
      logic [23:0] n;
      case ($urandom_range(0, 9))
         0:       n = 24'd0;
         7:       n = 24'($urandom_range(1, 63));
         8:       n = 24'($urandom_range(701, 5000));
         9:       n = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'($urandom);
         default: n = 24'($urandom_range(1, 700));
      endcase
      return {8'($urandom), n};
   endfunction

   function automatic logic [31:0] pick_sustain();
      logic [16:0] s;
      case ($urandom_range(0, 5))
         0:       s = 17'd0;
         1:       s = 17'd65536;
         2:       s = 17'($urandom_range(65537, 131071));
         default: s = 17'($urandom_range(1, 65535));
      endcase
      return {15'($urandom), s};
   endfunction

   function automatic logic [31:0] pick_factor();
      logic [15:0] f;
      case ($urandom_range(0, 7))
         0:       f = 16'd0;
         1:       f = 16'hFFFF;
         2:       f = 16'($urandom);
         default: f = 16'($urandom_range(30000, 65535));
      endcase
      return {16'($urandom), f};
   endfunction

   task automatic queue_word(input logic [FUNC_W-1:0] f, input logic [VELOCITY_W-1:0] v);
      req_word_type w;
      w.func     = f;
      w.velocity = v;
      word_backlog.insert(word_backlog.size(), w);
      words_queued++;
   endtask

   // Mostly note on / ticks / note off sequences, with some raw noise words
   task automatic random_words(input int count);
      int made;
      int k;
      made = 0;
      while (made < count) begin
         if ($urandom_range(0, 4) != 0) begin
            queue_word(FUNC_NOTE_ON, 7'($urandom));
            k = $urandom_range(0, 24);
            repeat (k) queue_word(FUNC_TICK, 7'($urandom));
            made += k + 1;
            if ($urandom_range(0, 5) != 0) begin
               queue_word(FUNC_NOTE_OFF, 7'($urandom));
               made++;
            end
            k = $urandom_range(0, 12);
            repeat (k) queue_word(FUNC_TICK, 7'($urandom));
            made += k;
         end else begin
            k = $urandom_range(1, 6);
            repeat (k) queue_word(2'($urandom), 7'($urandom));
            made += k;
         end
      end
   endtask

   // Hold the sender until every word is taken and every result is back
   task automatic drain();
      while (words_taken != words_queued || expected_env.size() != 0) @(negedge clock);
   endtask

   initial begin
      env_cfg = '0;
      env_cfg.sustain_level = LEVEL_ONE;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Reset defaults: idle tick, note off from none, unused code, full sustain
      queue_word(FUNC_TICK, 7'h7F);
      queue_word(FUNC_NOTE_OFF, 7'h00);
      queue_word(2'd3, 7'h55);
      queue_word(FUNC_NOTE_ON, 7'd127);
      queue_word(FUNC_TICK, 7'h2A);
      drain();

      // Every segment in turn, fast release, late note off, restart
      load_setup(32'd64, 32'd100, 32'd64, 32'd200, 32'd32768, 32'd0, 32'd50000, 32'd0);
      queue_word(FUNC_NOTE_ON, 7'd0);
      repeat (7) queue_word(FUNC_TICK, 7'd0);
      queue_word(FUNC_NOTE_OFF, 7'd0);
      queue_word(FUNC_TICK, 7'd0);
      queue_word(FUNC_NOTE_OFF, 7'd0);
      queue_word(FUNC_NOTE_ON, 7'd127);
      drain();

      // Field extremes, sustain above one
      load_setup(32'hFFFFFF, 32'd1, 32'hFFFFFF, 32'hFFFFFF, 32'h1FFFF, 32'hFFFFFF,
                 32'hFFFF, 32'hFFFF);
      queue_word(FUNC_NOTE_ON, 7'd127);
      queue_word(FUNC_TICK, 7'd0);
      queue_word(FUNC_NOTE_OFF, 7'd0);
      queue_word(FUNC_TICK, 7'd0);
      drain();

      // Zero sustain: amplitude decay runs its full length
      load_setup(32'd0, 32'd0, 32'd0, 32'd128, 32'd0, 32'd64, 32'hFFFF, 32'hFFFF);
      queue_word(FUNC_NOTE_ON, 7'd1);
      queue_word(FUNC_TICK, 7'd0);
      queue_word(FUNC_TICK, 7'd0);
      queue_word(FUNC_NOTE_OFF, 7'd0);
      queue_word(FUNC_TICK, 7'd0);
      drain();

      // Random phases, each with its own register setting; no idling at the end
      for (int p = 0; p < 11; p++) begin
         idle_on = (p < 9) && ($urandom_range(0, 3) != 0);
         load_setup(pick_len(), pick_len(), pick_len(), pick_len(), pick_sustain(),
                    pick_len(), pick_factor(), pick_factor());
         random_words(100);
         drain();
      end

      repeat (100) @(negedge clock);
      mismatches += expected_env.size();
      if (mismatches == 0)
         $display("[dahdsr_envelope_generator] OK");
      else
         $display("[dahdsr_envelope_generator] ERROR");
      $finish;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("[dahdsr_envelope_generator] ERROR");
      $finish;
   end

endmodule
